@@ rtl/cpdm_pkg.sv @@
package cpdm_pkg;

    localparam int CNT_W     = 16;
    localparam int CLK_W     = 27;
    localparam int FREQ_W    = 35;
    localparam int DUTY_W    = 14;
    localparam int FRAC_BITS = 8;
    localparam int DIV_W     = FREQ_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int PROD_W    = CNT_W + DUTY_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(10000);

    localparam logic [CNT_W-1:0] LOAD_RESET  = CNT_W'(65535);
    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(32000000);

    localparam logic [2:0] ACT_EDGE     = 3'd0;
    localparam logic [2:0] ACT_COMBINED = 3'd1;
    localparam logic [2:0] ACT_UNDERFLOW = 3'd2;
    localparam logic [2:0] ACT_READ     = 3'd3;
    localparam logic [2:0] ACT_START    = 3'd4;
    localparam logic [2:0] ACT_STOP     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_LOAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

    localparam logic MODE_EDGE     = 1'b0;
    localparam logic MODE_COMBINED = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    typedef struct packed {
        logic [2:0]       action;
        logic [CNT_W-1:0] edge_count;
        logic [CNT_W-1:0] period_count;
        logic [CNT_W-1:0] high_count;
    } in_req_t;

    typedef struct packed {
        logic              status;
        logic [CNT_W-1:0]  period_len;
        logic [CNT_W-1:0]  high_len;
        logic [FREQ_W-1:0] frequency_q8;
        logic [DUTY_W-1:0] duty_hundredths;
    } out_res_t;

    typedef struct packed {
        logic apply;
        logic prep;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic div_done;
    } sts_t;

endpackage

@@ rtl/cpdm_div.sv @@
module cpdm_div
    import cpdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [CNT_W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W:0]       shifted;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign shifted = {rem_reg[CNT_W-1:0], quo_reg[DIV_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/cpdm_datapath.sv @@
module cpdm_datapath
    import cpdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  in_req_t              in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CLK_W-1:0]     cfg_data,
    output out_res_t             out_data
);

    logic [CNT_W-1:0]  load_reg, load_next;
    logic [CLK_W-1:0]  clk_hz_reg, clk_hz_next;
    logic              mode_reg, mode_next;

    logic [CNT_W-1:0]  period_reg, period_next;
    logic [CNT_W-1:0]  high_reg, high_next;
    logic              valid_reg, valid_next;
    logic              synced_reg, synced_next;
    logic [CNT_W-1:0]  prev_edge_reg, prev_edge_next;
    logic              edge_seen_reg, edge_seen_next;

    logic              nodata_reg;
    logic [PROD_W-1:0] prod_reg;
    out_res_t          out_reg;

    logic [CNT_W-1:0]  edge_diff;
    logic [CNT_W-1:0]  comb_period;
    logic [CNT_W-1:0]  comb_high;
    logic              freq_done;
    logic              duty_done;
    logic [DIV_W-1:0]  freq_quo;
    logic [DIV_W-1:0]  duty_quo;

    // edge difference wraps modulo load+1
    assign edge_diff = prev_edge_reg - in_data.edge_count
                     + ((prev_edge_reg < in_data.edge_count) ? (load_reg + 1'b1) : '0);
    assign comb_period = load_reg - in_data.period_count;
    assign comb_high   = load_reg - in_data.high_count;

    always_comb
    begin
        load_next      = load_reg;
        clk_hz_next    = clk_hz_reg;
        mode_next      = mode_reg;
        period_next    = period_reg;
        high_next      = high_reg;
        valid_next     = valid_reg;
        synced_next    = synced_reg;
        prev_edge_next = prev_edge_reg;
        edge_seen_next = edge_seen_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOAD:  load_next   = cfg_data[CNT_W-1:0];
                REG_CLOCK: clk_hz_next = cfg_data;
                REG_MODE:  mode_next   = cfg_data[0];
                default:   ;
            endcase
        end

        if (cmd.apply)
        begin
            case (in_data.action)
                ACT_EDGE:
                begin
                    if (mode_reg == MODE_EDGE)
                    begin
                        if (edge_seen_reg && (edge_diff != '0))
                        begin
                            period_next = edge_diff;
                            high_next   = '0;
                            valid_next  = 1'b1;
                        end
                        prev_edge_next = in_data.edge_count;
                        edge_seen_next = 1'b1;
                    end
                end
                ACT_COMBINED:
                begin
                    if (mode_reg == MODE_COMBINED)
                    begin
                        if (synced_reg)
                        begin
                            period_next = comb_period;
                            high_next   = comb_high;
                            valid_next  = (comb_period != '0) && (comb_high <= comb_period);
                        end
                        else
                        begin
                            synced_next = 1'b1;
                        end
                    end
                end
                ACT_UNDERFLOW:
                begin
                    if (mode_reg == MODE_COMBINED)
                    begin
                        valid_next  = 1'b0;
                        synced_next = 1'b0;
                    end
                end
                ACT_START:
                begin
                    valid_next     = 1'b0;
                    synced_next    = 1'b0;
                    prev_edge_next = '0;
                    edge_seen_next = 1'b0;
                end
                ACT_STOP:  valid_next = 1'b0;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg      <= LOAD_RESET;
            clk_hz_reg    <= CLOCK_RESET;
            mode_reg      <= MODE_EDGE;
            period_reg    <= '0;
            high_reg      <= '0;
            valid_reg     <= 1'b0;
            synced_reg    <= 1'b0;
            prev_edge_reg <= '0;
            edge_seen_reg <= 1'b0;
        end
        else
        begin
            load_reg      <= load_next;
            clk_hz_reg    <= clk_hz_next;
            mode_reg      <= mode_next;
            period_reg    <= period_next;
            high_reg      <= high_next;
            valid_reg     <= valid_next;
            synced_reg    <= synced_next;
            prev_edge_reg <= prev_edge_next;
            edge_seen_reg <= edge_seen_next;
        end
    end

    // read operands: duty numerator and the no-data verdict
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            prod_reg   <= PROD_W'(high_reg) * PROD_W'(DUTY_SCALE);
            nodata_reg <= !(valid_reg && (period_reg != '0) && (high_reg <= period_reg));
        end
        if (cmd.load_out)
        begin
            if (nodata_reg)
            begin
                out_reg.status          <= STATUS_NO_DATA;
                out_reg.period_len      <= '0;
                out_reg.high_len        <= '0;
                out_reg.frequency_q8    <= '0;
                out_reg.duty_hundredths <= '0;
            end
            else
            begin
                out_reg.status          <= STATUS_OK;
                out_reg.period_len      <= period_reg;
                out_reg.high_len        <= high_reg;
                out_reg.frequency_q8    <= freq_quo[FREQ_W-1:0];
                out_reg.duty_hundredths <= duty_quo[DUTY_W-1:0];
            end
        end
    end

    cpdm_div u_freq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({clk_hz_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (period_reg),
        .done     (freq_done),
        .quotient (freq_quo)
    );

    cpdm_div u_duty_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (DIV_W'(prod_reg)),
        .divisor  (period_reg),
        .done     (duty_done),
        .quotient (duty_quo)
    );

    assign sts.is_read  = (in_data.action == ACT_READ);
    assign sts.div_done = freq_done && duty_done;
    assign out_data     = out_reg;

endmodule

@@ rtl/cpdm_ctrl.sv @@
module cpdm_ctrl
    import cpdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.apply = 1'b1;
                    if (sts.is_read)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = (out_valid_reg && out_stall) || cmd.load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/capture_period_duty_meter_top.sv @@
// Channel   Direction  Handshake            Contents
// in        request    in_valid / in_stall  action and captured counter values
// out       result     out_valid/out_stall  status, period, high, frequency, duty
// cfg       write      cfg_valid/cfg_ready  register index and write data
//
// Captures, underflow, start and stop give no result and leave the input free.
// A read goes through prep, divider start, division and output load; the
// division runs on the two 35-step restoring dividers side by side.
// Reset clears all measurement state and loads the register defaults.
// A pending result waits in its register while new requests are taken; a
// read that finishes while the result is still stalled holds until it drains.
module capture_period_duty_meter_top
    import cpdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_req_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_res_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CLK_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // registers always writable; user must write only when idle, not enforced
    assign cfg_ready = 1'b1;

    cpdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpdm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    // a read request must hold off the input side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_data.action == ACT_READ)) |=> in_stall)
        else $error("read accepted without holding input");

    // never overwrite a result that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("result overwritten while stalled");

    // division completes only while a read is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> in_stall)
        else $error("divider finished outside a read");

endmodule

@@ tb/tb_capture_period_duty_meter_top.sv @@
module tb_capture_period_duty_meter_top;
    import cpdm_pkg::*;

    // Spare action codes the block must ignore.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int unsigned HUNDREDTHS_FULL = 10000;
    localparam logic [CLK_W-1:0] CLOCK_TOP = CLK_W'(100000000);
    localparam logic [CLK_W-1:0] CLOCK_ALL_ONES = {CLK_W{1'b1}};
    localparam logic [CLK_W-1:0] CLOCK_DEFAULT = CLK_W'(32000000);

    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_res_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LOAD;
    logic [CLK_W-1:0] cfg_data = '0;

    // Local copy of the meter: configuration and measurement state.
    logic [CNT_W-1:0] m_load = LOAD_RESET;
    logic [CLK_W-1:0] m_clock_hz = CLOCK_RESET;
    logic             m_mode = MODE_EDGE;
    logic [CNT_W-1:0] m_period = '0;
    logic [CNT_W-1:0] m_high = '0;
    logic             m_valid = 1'b0;
    logic             m_synced = 1'b0;
    logic [CNT_W-1:0] m_last_edge = '0;
    logic             m_edge_seen = 1'b0;

    out_res_t pending_readings[$];
    out_res_t want_res;

    int n_requests = 0;
    int n_reads = 0;
    int n_edge_caps = 0;
    int n_comb_caps = 0;
    int n_reg_writes = 0;
    int n_settings = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int idle_cycles = 0;

    // Receiver pacing state.
    bit    hold_req = 1'b0;
    int    hold_left = 0;
    flow_t flow = FLOW_FREE;
    int    flow_left = 0;

    capture_period_duty_meter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic in_req_t req(input logic [2:0] act, input logic [CNT_W-1:0] e,
                                    input logic [CNT_W-1:0] pc, input logic [CNT_W-1:0] hc);
        in_req_t r;
        r.action = act;
        r.edge_count = e;
        r.period_count = pc;
        r.high_count = hc;
        return r;
    endfunction

    task automatic flag(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Advance the local meter by one accepted request; queue the reading a read gives.
    task automatic advance_meter(input in_req_t r);
        logic [17:0] span;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] h;
        logic [FREQ_W-1:0] scaled;
        logic [31:0] prod;
        out_res_t exp_res;
        n_requests++;
        case (r.action)
            ACT_EDGE:
            begin
                n_edge_caps++;
                if (m_mode == MODE_EDGE)
                begin
                    if (m_edge_seen)
                    begin
                        // Down-counter: earlier capture minus later one, wrap at load+1.
                        if (m_last_edge >= r.edge_count)
                            span = m_last_edge - r.edge_count;
                        else
                            span = m_last_edge + m_load + 18'd1 - r.edge_count;
                        if (span[CNT_W-1:0] != '0)
                        begin
                            m_period = span[CNT_W-1:0];
                            m_high = '0;
                            m_valid = 1'b1;
                        end
                    end
                    m_last_edge = r.edge_count;
                    m_edge_seen = 1'b1;
                end
            end
            ACT_COMBINED:
            begin
                n_comb_caps++;
                if (m_mode == MODE_COMBINED)
                begin
                    if (m_synced)
                    begin
                        p = m_load - r.period_count;
                        h = m_load - r.high_count;
                        m_period = p;
                        m_high = h;
                        m_valid = (p != '0) && (h <= p);
                    end
                    else
                        m_synced = 1'b1;
                end
            end
            ACT_UNDERFLOW:
            begin
                if (m_mode == MODE_COMBINED)
                begin
                    m_valid = 1'b0;
                    m_synced = 1'b0;
                end
            end
            ACT_READ:
            begin
                n_reads++;
                exp_res = '0;
                if (m_valid && m_period != '0 && m_high <= m_period)
                begin
                    exp_res.status = STATUS_OK;
                    exp_res.period_len = m_period;
                    exp_res.high_len = m_high;
                    scaled = {m_clock_hz, {FRAC_BITS{1'b0}}};
                    exp_res.frequency_q8 = scaled / FREQ_W'(m_period);
                    prod = 32'(m_high) * HUNDREDTHS_FULL;
                    exp_res.duty_hundredths = DUTY_W'(prod / 32'(m_period));
                end
                else
                    exp_res.status = STATUS_NO_DATA;
                pending_readings.push_back(exp_res);
            end
            ACT_START:
            begin
                m_valid = 1'b0;
                m_synced = 1'b0;
                m_last_edge = '0;
                m_edge_seen = 1'b0;
            end
            ACT_STOP:
                m_valid = 1'b0;
            default:
                ;
        endcase
    endtask

    // Offer one request and hold it until taken. Drop valid afterwards unless
    // another request follows in this same step.
    task automatic send_req(input in_req_t r, input bit keep);
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_meter(r);
        if (!keep)
            in_valid <= 1'b0;
    endtask

    // Send a list of requests in bursts of random length with random gaps.
    task automatic play_requests(input in_req_t items[$], input bit tight);
        int burst_left;
        int idx;
        int gap;
        bit keep;
        burst_left = 0;
        for (idx = 0; idx < items.size(); idx++)
        begin
            if (burst_left == 0)
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 16);
            burst_left--;
            keep = tight || burst_left != 0;
            if (idx == items.size() - 1)
                keep = 1'b0;
            send_req(items[idx], keep);
            if (!keep && idx != items.size() - 1)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(1, 4);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait until every queued reading has come back.
    task automatic quiesce();
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] val,
                             input bit keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!keep)
            cfg_valid <= 1'b0;
        n_reg_writes++;
        case (idx)
            REG_LOAD:  m_load = val[CNT_W-1:0];
            REG_CLOCK: m_clock_hz = val;
            REG_MODE:  m_mode = val[0];
            default:   ;
        endcase
    endtask

    // Drain, let any capture still in flight finish, then write all registers.
    task automatic configure(input logic [CLK_W-1:0] load_word,
                             input logic [CLK_W-1:0] clock_word,
                             input logic [CLK_W-1:0] mode_word);
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LOAD, load_word, 1'b1);
        write_reg(REG_CLOCK, clock_word, 1'b1);
        write_reg(REG_MODE, mode_word, 1'b0);
        n_settings++;
    endtask

    function automatic logic [CNT_W-1:0] capture_value();
        if ($urandom_range(0, 5) == 0)
            return CNT_W'($urandom);
        return CNT_W'($urandom_range(0, int'(m_load)));
    endfunction

    // Mostly well-formed traffic for the current mode, with some noise.
    function automatic in_req_t random_request();
        in_req_t r;
        int pick;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        r = req(ACT_READ, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            r.action = 3'($urandom_range(0, 7));
        else if (pick < 16)
            r.action = ACT_START;
        else if (pick < 19)
            r.action = ACT_STOP;
        else if (pick < 50)
            r.action = ACT_READ;
        else if (m_mode == MODE_EDGE)
        begin
            r.action = ACT_EDGE;
            r.edge_count = capture_value();
        end
        else if (pick < 54)
            r.action = ACT_UNDERFLOW;
        else
        begin
            r.action = ACT_COMBINED;
            a = capture_value();
            b = capture_value();
            // Keep high end after period end most of the time: high <= period.
            if ($urandom_range(0, 4) != 0 && b < a)
            begin
                r.period_count = b;
                r.high_count = a;
            end
            else
            begin
                r.period_count = a;
                r.high_count = b;
            end
        end
        return r;
    endfunction

    task automatic play_random(input int count, input bit tight);
        in_req_t items[$];
        repeat (count) items.push_back(random_request());
        play_requests(items, tight);
    endtask

    // Edge mode under reset defaults: first edge, wrap, zero period, ignored actions.
    task automatic test_edge_directed();
        in_req_t items[$];
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_EDGE, '1, '0, '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_EDGE, '0, '1, '1));
        items.push_back(req(ACT_EDGE, '0, '0, '0));
        items.push_back(req(ACT_READ, '1, '1, '1));
        items.push_back(req(ACT_EDGE, '1, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, '0, '1));
        items.push_back(req(ACT_UNDERFLOW, '0, '0, '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_STOP, '0, '0, '0));
        items.push_back(req(ACT_EDGE, CNT_W'(100), '0, '0));
        items.push_back(req(ACT_SPARE_LO, '1, '1, '1));
        items.push_back(req(ACT_SPARE_HI, CNT_W'($urandom), CNT_W'($urandom), '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_START, '0, '0, '0));
        items.push_back(req(ACT_EDGE, CNT_W'(500), '0, '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        play_requests(items, 1'b0);
    endtask

    // Combined mode: sync, high above period, capture above load, zero period.
    task automatic test_combined_directed();
        in_req_t items[$];
        configure(CLK_W'(1000), CLOCK_DEFAULT, CLK_W'(MODE_COMBINED));
        items.push_back(req(ACT_START, '0, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, '0, CNT_W'(500)));
        items.push_back(req(ACT_COMBINED, '0, '0, CNT_W'(500)));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, CNT_W'(900), '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, '1, '1));
        items.push_back(req(ACT_EDGE, CNT_W'(3), '0, '0));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, CNT_W'(1000), CNT_W'(1000)));
        items.push_back(req(ACT_READ, '0, '0, '0));
        items.push_back(req(ACT_UNDERFLOW, '0, '0, '0));
        items.push_back(req(ACT_COMBINED, '0, CNT_W'(10), CNT_W'(20)));
        items.push_back(req(ACT_READ, '0, '0, '0));
        play_requests(items, 1'b0);
    endtask

    // Random traffic over a range of settings, the register extremes among them.
    task automatic test_random_settings();
        configure(CLK_W'(LOAD_RESET), CLOCK_DEFAULT, CLK_W'(MODE_EDGE));
        play_random(160, 1'b0);
        configure(CLK_W'(2), CLK_W'(1), CLK_W'(MODE_COMBINED));
        play_random(160, 1'b0);
        configure(CLK_W'(1000), CLOCK_TOP, CLK_W'(MODE_EDGE));
        play_random(160, 1'b0);
        configure(CLK_W'(LOAD_RESET), CLOCK_ALL_ONES, CLK_W'(MODE_COMBINED));
        play_random(160, 1'b0);
        configure(CLK_W'(1), '0, CLK_W'(MODE_EDGE));
        play_random(160, 1'b0);
        configure('0, CLOCK_TOP, CLK_W'(MODE_COMBINED));
        play_random(160, 1'b0);
        repeat (2)
        begin
            // Unused upper bits of the write data are set at random.
            configure(CLK_W'($urandom), CLK_W'($urandom_range(0, int'(CLOCK_ALL_ONES))),
                      CLK_W'($urandom));
            play_random(90, 1'b0);
        end
    endtask

    // Hold the receiver off while reads keep coming, so the block backs up.
    task automatic test_output_backlog();
        in_req_t items[$];
        configure(CLK_W'(4000), CLOCK_DEFAULT, CLK_W'(MODE_EDGE));
        items.push_back(req(ACT_START, '0, '0, '0));
        items.push_back(req(ACT_EDGE, CNT_W'(3000), '0, '0));
        items.push_back(req(ACT_EDGE, CNT_W'(1200), '0, '0));
        repeat (37)
            items.push_back(($urandom_range(0, 3) == 0) ? random_request()
                                                        : req(ACT_READ, '0, '0, '0));
        hold_req = 1'b1;
        play_requests(items, 1'b1);
        quiesce();
    endtask

    // Stop sending until every reading is back, then go on.
    task automatic test_sender_pause();
        play_random(20, 1'b0);
        quiesce();
        play_random(20, 1'b0);
    endtask

    task automatic finish_run();
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            flag($sformatf("%0d readings never arrived", pending_readings.size()));
        $display("Covered %0d requests: %0d reads, %0d edge and %0d combined captures.",
                 n_requests, n_reads, n_edge_caps, n_comb_caps);
        $display("%0d register writes over %0d settings; %0d results checked, %0d mismatches.",
                 n_reg_writes, n_settings, n_results, n_mismatch);
        if (n_mismatch == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_edge_directed();
        test_combined_directed();
        test_random_settings();
        test_output_backlog();
        test_sender_pause();
        finish_run();
    end

    // Receiver: pace with its own pattern of free, light and heavy stall
    // stretches; a pending hold request overrides it for HOLD_CYCLES.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (flow_left == 0)
            begin
                flow = flow_t'($urandom_range(0, 2));
                flow_left = $urandom_range(10, 150);
            end
            else
                flow_left--;
            case (flow)
                FLOW_FREE:  out_stall <= 1'b0;
                FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:    out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Compare each accepted result with the oldest queued reading.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_readings.size() == 0)
                flag($sformatf("Unexpected result: st=%0d per=%0d high=%0d freq=%0d duty=%0d",
                               out_data.status, out_data.period_len, out_data.high_len,
                               out_data.frequency_q8, out_data.duty_hundredths));
            else
            begin
                want_res = pending_readings.pop_front();
                if (out_data.status !== want_res.status
                    || out_data.period_len !== want_res.period_len
                    || out_data.high_len !== want_res.high_len
                    || out_data.frequency_q8 !== want_res.frequency_q8
                    || out_data.duty_hundredths !== want_res.duty_hundredths)
                    flag($sformatf({"Result %0d mismatch: exp st=%0d per=%0d high=%0d ",
                                    "freq=%0d duty=%0d, got st=%0d per=%0d high=%0d ",
                                    "freq=%0d duty=%0d"},
                                   n_results, want_res.status, want_res.period_len,
                                   want_res.high_len, want_res.frequency_q8,
                                   want_res.duty_hundredths, out_data.status,
                                   out_data.period_len, out_data.high_len,
                                   out_data.frequency_q8, out_data.duty_hundredths));
            end
        end
    end

    // Watchdog: end the run if no handshake completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles, %0d readings outstanding",
                         idle_cycles, pending_readings.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

@@ capture_period_duty_meter_top.f @@
rtl/cpdm_pkg.sv
rtl/cpdm_div.sv
rtl/cpdm_datapath.sv
rtl/cpdm_ctrl.sv
rtl/capture_period_duty_meter_top.sv
tb/tb_capture_period_duty_meter_top.sv
